// File: sv/kped_pkg.sv
// Shared types and constants for the key press event detector.
// No dependencies; imported by every module of the block.
package kped_pkg;

  localparam int unsigned KeyW   = 4;
  localparam int unsigned TickW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned EventW = 3;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [KeyW-1:0] KEYS_IDLE = 4'hF;

  localparam logic [CfgW-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CfgW-1:0] CLICK_MAX_RST = 16'd1000;
  localparam logic [CfgW-1:0] DOUBLE_RST = 16'd300;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_DEBOUNCE  = 2'd0,
    REG_CLICK_MAX = 2'd1,
    REG_DOUBLE    = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_t;

  typedef enum logic [EventW-1:0] {
    EV_NONE     = 3'd0,
    EV_LONG     = 3'd1,
    EV_LONG_UP  = 3'd2,
    EV_DOUBLE   = 3'd3,
    EV_SHORT_UP = 3'd4
  } event_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ticks;
    logic [CfgW-1:0] click_max_ticks;
    logic [CfgW-1:0] double_click_ticks;
  } cfg_t;

  typedef struct packed {
    event_t          event_res;
    logic [KeyW-1:0] held_keys;
  } result_t;

  typedef struct packed {
    logic pressed;
    logic wait_release;
  } core_stat_t;

endpackage

// File: sv/kped_cfg.sv
// APB-style configuration registers of the key press event detector.
// Depends on kped_pkg.
module kped_cfg
  import kped_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks     <= DEBOUNCE_RST;
      cfg_r.click_max_ticks    <= CLICK_MAX_RST;
      cfg_r.double_click_ticks <= DOUBLE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_DEBOUNCE:  cfg_r.debounce_ticks     <= pwdata[CfgW-1:0];
        REG_CLICK_MAX: cfg_r.click_max_ticks    <= pwdata[CfgW-1:0];
        REG_DOUBLE:    cfg_r.double_click_ticks <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEBOUNCE:  prdata = {{(DataW-CfgW){1'b0}}, cfg_r.debounce_ticks};
      REG_CLICK_MAX: prdata = {{(DataW-CfgW){1'b0}}, cfg_r.click_max_ticks};
      REG_DOUBLE:    prdata = {{(DataW-CfgW){1'b0}}, cfg_r.double_click_ticks};
      default:       prdata = '0;
    endcase
  end

endmodule

// File: sv/kped_core.sv
// Press tracking state and event decision for one scan request.
// Depends on kped_pkg.
module kped_core
  import kped_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [KeyW-1:0]  keys_n,
  input  logic [TickW-1:0] now_ticks,
  input  cfg_t             cfg,
  output result_t          res,
  output core_stat_t       stat
);

  logic [TickW-1:0] press_start_r, press_start_nxt;
  logic [TickW-1:0] click_start_r, click_start_nxt;
  logic [TickW-1:0] last_click_r, last_click_nxt;
  logic [KeyW-1:0]  captured_r, captured_nxt;
  logic             pressed_r, pressed_nxt;
  logic             wait_r, wait_nxt;
  logic             double_r, double_nxt;
  logic             pending_r, pending_nxt;

  logic [TickW-1:0] held, since_last, since_click;
  logic [TickW-1:0] deb_x, cmax_x, dbl_x;
  event_t           ev;

  assign deb_x  = {{(TickW-CfgW){1'b0}}, cfg.debounce_ticks};
  assign cmax_x = {{(TickW-CfgW){1'b0}}, cfg.click_max_ticks};
  assign dbl_x  = {{(TickW-CfgW){1'b0}}, cfg.double_click_ticks};

  assign held       = now_ticks - press_start_r;
  assign since_last = now_ticks - last_click_r;

  always_comb begin
    press_start_nxt = press_start_r;
    click_start_nxt = click_start_r;
    last_click_nxt  = last_click_r;
    captured_nxt    = captured_r;
    pressed_nxt     = pressed_r;
    wait_nxt        = wait_r;
    double_nxt      = double_r;
    pending_nxt     = pending_r;
    since_click     = '0;
    ev              = EV_NONE;

    if (!(wait_r && keys_n == captured_r)) begin
      if (wait_r) begin
        wait_nxt = 1'b0;
        ev       = EV_LONG_UP;
      end
      if (keys_n != KEYS_IDLE) begin
        if (!pressed_r) begin
          pressed_nxt     = 1'b1;
          captured_nxt    = keys_n;
          press_start_nxt = now_ticks;
        end else if (captured_r == keys_n) begin
          if (held > deb_x && held > cmax_x) begin
            pressed_nxt = 1'b0;
            wait_nxt    = 1'b1;
            ev          = EV_LONG;
          end
        end
      end else if (!(pressed_r && held <= deb_x)) begin
        // A press that is still inside the debounce time leaves everything as is.
        if (pressed_r && held <= cmax_x) begin
          if (since_last <= dbl_x) begin
            double_nxt = 1'b1;
            ev         = EV_DOUBLE;
          end else begin
            pending_nxt     = 1'b1;
            double_nxt      = 1'b0;
            click_start_nxt = now_ticks;
          end
          last_click_nxt = now_ticks;
        end
        since_click = now_ticks - click_start_nxt;
        if (pending_nxt && since_click > dbl_x && !double_nxt) begin
          ev          = EV_SHORT_UP;
          pending_nxt = 1'b0;
          double_nxt  = 1'b0;
        end
        pressed_nxt = 1'b0;
      end
    end
  end

  assign res.event_res = ev;
  assign res.held_keys = captured_nxt;

  assign stat.pressed      = pressed_r;
  assign stat.wait_release = wait_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_start_r <= '0;
      click_start_r <= '0;
      last_click_r  <= '0;
      captured_r    <= '0;
      pressed_r     <= 1'b0;
      wait_r        <= 1'b0;
      double_r      <= 1'b0;
      pending_r     <= 1'b0;
    end else if (push) begin
      press_start_r <= press_start_nxt;
      click_start_r <= click_start_nxt;
      last_click_r  <= last_click_nxt;
      captured_r    <= captured_nxt;
      pressed_r     <= pressed_nxt;
      wait_r        <= wait_nxt;
      double_r      <= double_nxt;
      pending_r     <= pending_nxt;
    end
  end

endmodule

// File: sv/kped_skid.sv
// Output register with a one-entry skid stage for result requests.
// Depends on kped_pkg.
module kped_skid
  import kped_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;
  logic    pop;

  assign pop       = out_valid_r && out_ready;
  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_r <= skid_valid_r ? skid_r : push_data;
    end
    if (push && out_valid_r && !pop) begin
      skid_r <= push_data;
    end
  end

endmodule

// File: sv/key_press_event_detector.sv
// Top level of the key press event detector: configuration, core and output buffer.
// Depends on kped_pkg, kped_cfg, kped_core and kped_skid.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------
//   in       | in_valid / in_ready   | in_keys_n[3:0], in_now_ticks[31:0]
//   out      | out_valid / out_ready | out_event_res[2:0], out_held_keys[3:0]
//   cfg      | psel/penable/pwrite   | paddr[3:0], pwdata, prdata; pready high
//
// Each scan request is decided in the cycle it is accepted; its result is written
// into the result register, or into the skid entry while that register still
// waits. One request can be taken every cycle while in_ready is high. The press
// state registers update at the accepting edge, so the next request sees them at
// once. A two-entry output stage (result register plus skid) keeps in_ready high
// while one result waits; in_ready drops only when both are full. Reset is
// synchronous and restores the register defaults (debounce 20, click maximum
// 1000, double click window 300) and clears all press state.
module key_press_event_detector
  import kped_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // scan requests
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KeyW-1:0]   in_keys_n,
  input  logic [TickW-1:0]  in_now_ticks,
  // event results
  output logic              out_valid,
  input  logic              out_ready,
  output logic [EventW-1:0] out_event_res,
  output logic [KeyW-1:0]   out_held_keys,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  cfg_t       cfg;
  result_t    core_res;
  result_t    out_data;
  core_stat_t core_stat;
  logic       push;

  // A request is taken whenever the skid stage has room.
  assign push = in_valid && in_ready;

  kped_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kped_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .keys_n    (in_keys_n),
    .now_ticks (in_now_ticks),
    .cfg       (cfg),
    .res       (core_res),
    .stat      (core_stat)
  );

  kped_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (core_res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_event_res = out_data.event_res;
  assign out_held_keys = out_data.held_keys;

`ifndef NO_ASSERTIONS
  // Back pressure only appears when a result is already being shown.
  a_ready_implies_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low while the result register is empty");

  // After every accepted request the output is valid in the following cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted request did not reach the output");

  // A long press clears the pressed state as it starts waiting for release.
  a_wait_not_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    !(core_stat.pressed && core_stat.wait_release))
    else $error("pressed and wait-for-release both set");
`endif

endmodule

// File: bench/key_event_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the key press event detector: watches the scan, result and
// register ports, predicts one event per scan request and compares it.
// Depends on kped_pkg for widths, register indexes and event codes.
module key_event_checker
  import kped_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [KeyW-1:0]   in_keys_n,
  input  logic [TickW-1:0]  in_now_ticks,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [EventW-1:0] out_event_res,
  input  logic [KeyW-1:0]   out_held_keys,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output int                fail_count,
  output int                events_pending
);

  cfg_t             cfg;
  logic [TickW-1:0] start_tick;
  logic [TickW-1:0] single_tick;
  logic [TickW-1:0] prev_click_tick;
  logic [KeyW-1:0]  press_keys;
  logic             in_press;
  logic             hold_for_release;
  logic             after_double;
  logic             single_waiting;
  result_t          expected_events[$];

  initial begin
    fail_count = 0;
    events_pending = 0;
  end

  // Advances the predicted press state by one scan and returns its event.
  task automatic resolve_scan(input logic [KeyW-1:0] keys, input logic [TickW-1:0] now,
                              output event_t ev);
    logic [TickW-1:0] held;
    logic [TickW-1:0] since_click;
    logic [TickW-1:0] since_single;
    logic             settled;
    ev = EV_NONE;
    settled = 1'b0;
    held = now - start_tick;
    if (hold_for_release) begin
      if (keys == press_keys) begin
        settled = 1'b1;
      end else begin
        hold_for_release = 1'b0;
        ev = EV_LONG_UP;
      end
    end
    if (!settled && keys != KEYS_IDLE) begin
      if (!in_press) begin
        in_press = 1'b1;
        press_keys = keys;
        start_tick = now;
      end else if (press_keys == keys) begin
        if (held > TickW'(cfg.debounce_ticks) && held > TickW'(cfg.click_max_ticks)) begin
          in_press = 1'b0;
          hold_for_release = 1'b1;
          ev = EV_LONG;
        end
      end
    end else if (!settled) begin
      // A release that comes too soon leaves the press open; a later idle
      // scan resolves it once enough time has gone by.
      if (!(in_press && held <= TickW'(cfg.debounce_ticks))) begin
        if (in_press && held <= TickW'(cfg.click_max_ticks)) begin
          since_click = now - prev_click_tick;
          if (since_click <= TickW'(cfg.double_click_ticks)) begin
            after_double = 1'b1;
            ev = EV_DOUBLE;
          end else begin
            single_waiting = 1'b1;
            after_double = 1'b0;
            single_tick = now;
          end
          prev_click_tick = now;
        end
        since_single = now - single_tick;
        if (single_waiting && since_single > TickW'(cfg.double_click_ticks) && !after_double) begin
          ev = EV_SHORT_UP;
          single_waiting = 1'b0;
          after_double = 1'b0;
        end
        in_press = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    event_t  ev;
    result_t want;
    if (!rst_n) begin
      cfg = '{DEBOUNCE_RST, CLICK_MAX_RST, DOUBLE_RST};
      start_tick = '0;
      single_tick = '0;
      prev_click_tick = '0;
      press_keys = '0;
      in_press = 1'b0;
      hold_for_release = 1'b0;
      after_double = 1'b0;
      single_waiting = 1'b0;
      expected_events.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_DEBOUNCE:  cfg.debounce_ticks = pwdata[CfgW-1:0];
          REG_CLICK_MAX: cfg.click_max_ticks = pwdata[CfgW-1:0];
          REG_DOUBLE:    cfg.double_click_ticks = pwdata[CfgW-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          fail_count++;
          $display("%0t: event %0d keys %h arrived with nothing expected",
                   $time, out_event_res, out_held_keys);
        end else begin
          want = expected_events.pop_front();
          if (out_event_res !== want.event_res || out_held_keys !== want.held_keys) begin
            fail_count++;
            $display("%0t: expected event %0d keys %h, actual event %0d keys %h", $time,
                     want.event_res, want.held_keys, out_event_res, out_held_keys);
          end
        end
      end
      if (in_valid && in_ready) begin
        resolve_scan(in_keys_n, in_now_ticks, ev);
        want.event_res = ev;
        want.held_keys = press_keys;
        expected_events.push_back(want);
      end
    end
    events_pending = expected_events.size();
  end

endmodule

// File: bench/tb_key_press_event_detector.sv
`timescale 1ns / 1ps
// Top of the key press event detector bench: clock, reset, scan and register
// stimulus, watchdog and verdict. Depends on kped_pkg, the block and key_event_checker.
module tb_key_press_event_detector;
  import kped_pkg::*;

  // Cycles without any accepted request, result or register access before the run is declared hung.
  localparam int QuietLimit = 2000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [KeyW-1:0]   in_keys_n;
  logic [TickW-1:0]  in_now_ticks;
  logic              out_valid;
  logic              out_ready;
  logic [EventW-1:0] out_event_res;
  logic [KeyW-1:0]   out_held_keys;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  int                fail_count;
  int                events_pending;
  int                quiet_cycles = 0;
  int                scans_sent = 0;
  int unsigned       idle_pct;
  int unsigned       stall_pct;
  // The register values last written; press lengths and gaps are drawn
  // around them so that every kind of event keeps showing up.
  int unsigned       deb_set = DEBOUNCE_RST;
  int unsigned       cmx_set = CLICK_MAX_RST;
  int unsigned       dbl_set = DOUBLE_RST;
  logic [TickW-1:0]  tick_now;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  key_press_event_detector DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_keys_n    (in_keys_n),
    .in_now_ticks (in_now_ticks),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_event_res(out_event_res),
    .out_held_keys(out_held_keys),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  key_event_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_keys_n     (in_keys_n),
    .in_now_ticks  (in_now_ticks),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_res (out_event_res),
    .out_held_keys (out_held_keys),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .events_pending(events_pending)
  );

  // The result side stalls on its own schedule, one decision per cycle,
  // always made at the falling edge so the block samples a stable level.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Any accepted request, any accepted result or a register access counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("tb_key_press_event_detector NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Picks a value in [lo, hi], landing on either end half of the time so the
  // comparisons against the register values are hit exactly.
  function automatic int unsigned span(input int unsigned lo, input int unsigned hi);
    if (hi <= lo) return lo;
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // Sends one scan request. Called and returning at a falling edge; valid
  // only drops when the sender decides to idle before the next request.
  task automatic send_scan(input logic [KeyW-1:0] keys, input logic [TickW-1:0] now);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_keys_n <= keys;
    in_now_ticks <= now;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    scans_sent++;
  endtask

  // Setup and access cycle of one register write.
  task automatic cfg_write(input reg_idx_t idx, input logic [DataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'({idx, 2'b00});
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Stops sending and waits until every predicted event has come out, then
  // lets the output stage empty.
  task automatic settle();
    in_valid <= 1'b0;
    wait (events_pending == 0);
    @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One press and its release, followed by up to three idle scans. The press is a
  // bounce, a click or a long press; some scans in the middle carry another
  // key pattern, and a long press is sometimes ended by a new pattern rather
  // than by letting go of every key.
  task automatic press_burst();
    logic [KeyW-1:0]  pat;
    logic [KeyW-1:0]  alt;
    logic [TickW-1:0] t0;
    int unsigned      dur;
    int unsigned      top_ticks;
    int unsigned      kind;
    pat = KeyW'($urandom_range(0, 14));
    top_ticks = (deb_set > cmx_set) ? deb_set : cmx_set;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      dur = span(0, deb_set);
    end else if (kind < 7 && cmx_set > deb_set) begin
      dur = span(deb_set + 1, cmx_set);
    end else begin
      dur = span(top_ticks + 1, top_ticks + 64);
    end
    t0 = tick_now + $urandom_range(0, 5);
    send_scan(pat, t0);
    repeat ($urandom_range(0, 3)) begin
      alt = ($urandom_range(0, 4) == 0) ? KeyW'($urandom_range(0, 14)) : pat;
      send_scan(alt, t0 + $urandom_range(0, dur));
    end
    if (dur > top_ticks) begin
      send_scan(pat, t0 + dur);
      repeat ($urandom_range(0, 2)) send_scan(pat, t0 + dur + $urandom_range(0, 50));
      alt = ($urandom_range(0, 3) == 0) ? KeyW'($urandom_range(0, 14)) : KEYS_IDLE;
    end else begin
      alt = KEYS_IDLE;
    end
    tick_now = t0 + dur;
    send_scan(alt, tick_now);
    // Idle scans spaced around the double click window decide whether a
    // pending click is reported or the next press turns it into a double.
    repeat ($urandom_range(0, 3)) begin
      tick_now += span(0, dbl_set + 1);
      send_scan(KEYS_IDLE, tick_now);
    end
  endtask

  // Reprograms all registers while the block is idle, then runs random
  // presses with the given idling until the phase has sent its share.
  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input int unsigned deb, input int unsigned cmx,
                           input int unsigned dbl, input int items);
    int goal;
    settle();
    deb_set = deb;
    cmx_set = cmx;
    dbl_set = dbl;
    // The upper half of each write carries noise; only 16 bits are kept.
    cfg_write(REG_DEBOUNCE, {16'($urandom), 16'(deb)});
    cfg_write(REG_CLICK_MAX, {16'($urandom), 16'(cmx)});
    cfg_write(REG_DOUBLE, {16'($urandom), 16'(dbl)});
    cfg_write(REG_UNUSED, $urandom);
    idle_pct = idle;
    stall_pct = stall;
    goal = scans_sent + items;
    while (scans_sent < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        send_scan(KeyW'($urandom), $urandom);
      end else begin
        press_burst();
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_keys_n <= KEYS_IDLE;
    in_now_ticks <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    idle_pct = 0;
    stall_pct = 0;
    tick_now = $urandom;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed scans with the reset register values (debounce 20, click
    // maximum 1000, double click window 300).
    send_scan(KEYS_IDLE, 32'hFFFF_FFFF);
    // Long press with a pattern change in the middle, then released into a
    // new pattern, which opens a bounce-length press.
    send_scan(4'h0, 32'd5000);
    send_scan(4'h5, 32'd5010);
    send_scan(4'h0, 32'd6001);
    send_scan(4'h0, 32'd6100);
    send_scan(4'hA, 32'd6200);
    send_scan(KEYS_IDLE, 32'd6210);
    // The too-short press is resolved as a click by a later idle scan, and
    // the single click is reported once the window has passed.
    send_scan(KEYS_IDLE, 32'd6300);
    send_scan(KEYS_IDLE, 32'd6700);
    // A pending click plus a long press: the release scan reports the short
    // release over the long release.
    send_scan(4'h3, 32'd6900);
    send_scan(KEYS_IDLE, 32'd7000);
    send_scan(4'h3, 32'd7010);
    send_scan(4'h3, 32'd8100);
    send_scan(KEYS_IDLE, 32'd8200);
    // Double click, an idle scan that must stay silent after it, then a
    // single click that clears the double and is reported later.
    send_scan(4'h7, 32'd9000);
    send_scan(KEYS_IDLE, 32'd9100);
    send_scan(4'h7, 32'd9150);
    send_scan(KEYS_IDLE, 32'd9200);
    send_scan(KEYS_IDLE, 32'd9600);
    send_scan(4'h7, 32'd9700);
    send_scan(KEYS_IDLE, 32'd9800);
    send_scan(KEYS_IDLE, 32'd10200);
    // A click whose press time wraps past the top of the tick counter.
    send_scan(4'hE, 32'hFFFF_FFF0);
    send_scan(KEYS_IDLE, 32'h0000_0010);

    run_phase(0, 0, 0, 0, 0, 250);
    run_phase(0, 0, 5, 40, 60, 250);
    run_phase(75, 0, 65535, 65535, 65535, 250);
    run_phase(0, 75, 3, 20, 30, 300);
    run_phase(34, 34, 20, 1000, 300, 350);
    run_phase(0, 0, 10, 12, 65535, 200);
    run_phase(34, 34, 100, 50, 7, 150);

    settle();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_key_press_event_detector OK");
    end else begin
      $display("tb_key_press_event_detector NOT OK");
    end
    $finish;
  end

endmodule
